[rtl/core/bdqs_pkg.sv]
// shared types, codes and microcode table for the bounded deque with search
// no dependencies; used by bounded_deque_with_search and its testbench
package bdqs_pkg;

   localparam int KIND_W   = 3;
   localparam int KEY_IN_W = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int TOTAL_W  = 5;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_HEAD = 3'd0,
      KIND_PUSH_TAIL = 3'd1,
      KIND_POP_HEAD  = 3'd2,
      KIND_POP_TAIL  = 3'd3,
      KIND_SEARCH    = 3'd4,
      KIND_REVERSE   = 3'd5
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_EMPTY    = 2'd1,
      STATUS_FULL     = 2'd2,
      STATUS_NOTFOUND = 2'd3
   } status_type;

   typedef struct packed {
      logic [KIND_W-1:0]          kind;
      logic signed [KEY_IN_W-1:0] key_value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    found_position;
      logic [TOTAL_W-1:0]  entry_total;
   } rsp_type;

   typedef enum logic [2:0] {
      STEP_IDLE      = 3'd0,
      STEP_PUSH      = 3'd1,
      STEP_POP       = 3'd2,
      STEP_REV       = 3'd3,
      STEP_NOP       = 3'd4,
      STEP_SRCH_INIT = 3'd5,
      STEP_SRCH_LOOP = 3'd6
   } step_type;

   typedef enum logic [2:0] {
      ACT_IDLE      = 3'd0,
      ACT_PUSH      = 3'd1,
      ACT_POP       = 3'd2,
      ACT_REV       = 3'd3,
      ACT_NOP       = 3'd4,
      ACT_SRCH_INIT = 3'd5,
      ACT_SRCH_CMP  = 3'd6
   } act_type;

   // one control word per step: datapath action, and where to go when not done
   typedef struct packed {
      act_type  act;
      step_type target;
   } ucw_type;

   function automatic ucw_type ucode(input step_type step);
      ucw_type w;
      unique case (step)
         STEP_IDLE:      w = '{act: ACT_IDLE,      target: STEP_IDLE};
         STEP_PUSH:      w = '{act: ACT_PUSH,      target: STEP_IDLE};
         STEP_POP:       w = '{act: ACT_POP,       target: STEP_IDLE};
         STEP_REV:       w = '{act: ACT_REV,       target: STEP_IDLE};
         STEP_NOP:       w = '{act: ACT_NOP,       target: STEP_IDLE};
         STEP_SRCH_INIT: w = '{act: ACT_SRCH_INIT, target: STEP_SRCH_LOOP};
         STEP_SRCH_LOOP: w = '{act: ACT_SRCH_CMP,  target: STEP_SRCH_LOOP};
         default:        w = '{act: ACT_IDLE,      target: STEP_IDLE};
      endcase
      return w;
   endfunction

   // entry step of each operation
   function automatic step_type dispatch(input logic [KIND_W-1:0] kind);
      step_type s;
      unique case (kind)
         KIND_PUSH_HEAD, KIND_PUSH_TAIL: s = STEP_PUSH;
         KIND_POP_HEAD, KIND_POP_TAIL:   s = STEP_POP;
         KIND_SEARCH:                    s = STEP_SRCH_INIT;
         KIND_REVERSE:                   s = STEP_REV;
         default:                        s = STEP_NOP;
      endcase
      return s;
   endfunction

endpackage

[rtl/core/bounded_deque_with_search.sv]
// channel   ports                       direction  handshake
// request   start, busy, req_word       in         taken when start and not busy
// response  rsp_strobe, rsp_word        out        one cycle, cannot be held off
//
// push, pop, reverse and unused kinds go back to idle from their entry step;
// rsp_strobe is registered as that step finishes
// search keeps busy through an init step and a compare loop that stops at the
// first match or after the last stored key (an empty store ends at init): one
// stored key per cycle through the single read port of the key store
// reset clears pointer, count and order flag; stored keys are not cleared
// depends on bdqs_pkg and bdqs_store
module bounded_deque_with_search #(
   parameter int DEPTH     = 16,
   parameter int KEY_WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  bdqs_pkg::req_type req_word,
   output logic             rsp_strobe,
   output bdqs_pkg::rsp_type rsp_word
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W:0]   DEPTH_W = (PTR_W + 1)'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   bdqs_pkg::step_type step_ff, step_in;
   bdqs_pkg::ucw_type  ucw;

   logic [bdqs_pkg::KIND_W-1:0] kind_ff;
   logic [KEY_WIDTH-1:0]        key_ff;
   logic [PTR_W-1:0]            front_ff, front_in;
   logic [CNT_W-1:0]            count_ff, count_in;
   logic                        rev_ff, rev_in;
   logic [PTR_W-1:0]            idx_ff, idx_in;
   logic                        rsp_strobe_ff;
   bdqs_pkg::rsp_type           rsp_word_ff;

   logic                        accept;
   logic                        done;
   bdqs_pkg::status_type        status;
   logic                        wr_en;
   logic [PTR_W-1:0]            wr_addr;
   logic [PTR_W-1:0]            rd_idx;
   logic [PTR_W-1:0]            rd_addr;
   logic [CNT_W-1:0]            rd_offs;
   logic [KEY_WIDTH-1:0]        rd_data;
   logic [KEY_WIDTH+bdqs_pkg::KEY_IN_W-1:0] key_ext;
   logic [PTR_W+bdqs_pkg::POS_W-1:0]        pos_full;
   logic [CNT_W+bdqs_pkg::TOTAL_W-1:0]      total_full;
   logic                        head_side;
   logic                        at_front;
   logic                        is_full;
   logic                        is_empty;
   logic [PTR_W-1:0]            front_dec;
   logic [PTR_W-1:0]            front_inc;
   logic                        match;
   logic                        last;

   function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                                 input logic [PTR_W-1:0] offs);
      logic [PTR_W:0] sum;
      logic [PTR_W:0] sub;
      sum = {1'b0, base} + {1'b0, offs};
      sub = sum - DEPTH_W;
      return (sum >= DEPTH_W) ? sub[PTR_W-1:0] : sum[PTR_W-1:0];
   endfunction

   assign accept  = start && !busy;
   assign busy    = (step_ff != bdqs_pkg::STEP_IDLE);
   assign ucw     = bdqs_pkg::ucode(step_ff);
   assign key_ext = {{KEY_WIDTH{req_word.key_value[bdqs_pkg::KEY_IN_W-1]}},
                     req_word.key_value};

   assign head_side = (kind_ff == bdqs_pkg::KIND_PUSH_HEAD) ||
                      (kind_ff == bdqs_pkg::KIND_POP_HEAD);
   assign at_front  = head_side ^ rev_ff;
   assign is_full   = (count_ff == DEPTH_C);
   assign is_empty  = (count_ff == '0);
   assign front_dec = (front_ff == '0) ? LAST_P : (front_ff - PTR_W'(1));
   assign front_inc = (front_ff == LAST_P) ? '0 : (front_ff + PTR_W'(1));
   assign match     = (rd_data == key_ff);
   assign last      = (CNT_W'(idx_ff) == (count_ff - CNT_W'(1)));
   assign rd_offs   = rev_ff ? (count_ff - CNT_W'(1) - CNT_W'(rd_idx))
                             : CNT_W'(rd_idx);
   assign rd_addr   = slot_of(front_ff, rd_offs[PTR_W-1:0]);
   assign pos_full  = {{bdqs_pkg::POS_W{1'b0}}, idx_ff};
   assign total_full = {{bdqs_pkg::TOTAL_W{1'b0}}, count_in};

   // next step
   always_comb begin
      if (step_ff == bdqs_pkg::STEP_IDLE) begin
         step_in = accept ? bdqs_pkg::dispatch(req_word.kind) : bdqs_pkg::STEP_IDLE;
      end else begin
         step_in = done ? bdqs_pkg::STEP_IDLE : ucw.target;
      end
   end

   // datapath control from the current control word
   always_comb begin
      done     = 1'b1;
      status   = bdqs_pkg::STATUS_OK;
      wr_en    = 1'b0;
      wr_addr  = front_dec;
      front_in = front_ff;
      count_in = count_ff;
      rev_in   = rev_ff;
      idx_in   = idx_ff;
      rd_idx   = idx_ff + PTR_W'(1);
      unique case (ucw.act)
         bdqs_pkg::ACT_IDLE: begin
            done = 1'b0;
         end
         bdqs_pkg::ACT_PUSH: begin
            if (is_full) begin
               status = bdqs_pkg::STATUS_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CNT_W'(1);
               if (at_front) begin
                  front_in = front_dec;
                  wr_addr  = front_dec;
               end else begin
                  wr_addr = slot_of(front_ff, count_ff[PTR_W-1:0]);
               end
            end
         end
         bdqs_pkg::ACT_POP: begin
            if (is_empty) begin
               status = bdqs_pkg::STATUS_EMPTY;
            end else begin
               count_in = count_ff - CNT_W'(1);
               if (at_front) begin
                  front_in = front_inc;
               end
            end
         end
         bdqs_pkg::ACT_REV: begin
            if (is_empty) begin
               status = bdqs_pkg::STATUS_EMPTY;
            end else begin
               rev_in = !rev_ff;
            end
         end
         bdqs_pkg::ACT_NOP: begin
            done = 1'b1;
         end
         bdqs_pkg::ACT_SRCH_INIT: begin
            rd_idx = '0;
            idx_in = '0;
            if (is_empty) begin
               status = bdqs_pkg::STATUS_EMPTY;
            end else begin
               done = 1'b0;
            end
         end
         bdqs_pkg::ACT_SRCH_CMP: begin
            if (match) begin
               status = bdqs_pkg::STATUS_OK;
            end else if (last) begin
               status = bdqs_pkg::STATUS_NOTFOUND;
            end else begin
               done   = 1'b0;
               idx_in = idx_ff + PTR_W'(1);
            end
         end
         default: begin
            done = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff       <= bdqs_pkg::STEP_IDLE;
         front_ff      <= '0;
         count_ff      <= '0;
         rev_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         step_ff       <= step_in;
         front_ff      <= front_in;
         count_ff      <= count_in;
         rev_ff        <= rev_in;
         rsp_strobe_ff <= busy && done;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff <= req_word.kind;
         key_ff  <= key_ext[KEY_WIDTH-1:0];
      end
      idx_ff <= idx_in;
      if (busy && done) begin
         rsp_word_ff.status         <= status;
         rsp_word_ff.found_position <= (ucw.act == bdqs_pkg::ACT_SRCH_CMP && match)
                                       ? pos_full[bdqs_pkg::POS_W-1:0]
                                       : '0;
         rsp_word_ff.entry_total    <= total_full[bdqs_pkg::TOTAL_W-1:0];
      end
   end

   bdqs_store #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (key_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

`ifndef SYNTHESIS
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted word did not start a sequence");

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("response strobe without a running sequence");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("entry count beyond depth");

   a_search_nonempty: assert property (@(posedge clock) disable iff (reset)
      (step_ff == bdqs_pkg::STEP_SRCH_LOOP) |-> (count_ff != '0))
      else $error("search loop running on an empty store");
`endif

endmodule

[rtl/core/bdqs_store.sv]
// key storage ring: one write port, one read port with registered read data
// depends on nothing beyond its parameters
module bdqs_store #(
   parameter int DEPTH     = 16,
   parameter int KEY_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [KEY_WIDTH-1:0]     wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [KEY_WIDTH-1:0]     rd_data
);

   logic [KEY_WIDTH-1:0] mem [DEPTH];
   logic [KEY_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[test/tb_bounded_deque_with_search.sv]
// self-checking testbench for bounded_deque_with_search: directed table, then random words
// depends on bdqs_pkg and the bounded_deque_with_search rtl
`timescale 1ns / 100ps

module tb_bounded_deque_with_search;

   localparam int DEPTH = 16;
   localparam int RANDOM_WORDS = 800;
   localparam int CALM_WORDS = 100;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [bdqs_pkg::KIND_W-1:0] KIND_SPARE_6 = 3'd6;
   localparam logic [bdqs_pkg::KIND_W-1:0] KIND_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [bdqs_pkg::KIND_W-1:0]   kind;
      logic [bdqs_pkg::KEY_IN_W-1:0] key;
      logic [4:0]                    reps;
      logic                          typed;
      bdqs_pkg::rsp_type             want;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   bdqs_pkg::req_type req_word = '0;
   logic              busy;
   logic              rsp_strobe;
   bdqs_pkg::rsp_type rsp_word;

   logic [bdqs_pkg::KEY_IN_W-1:0] model_keys [DEPTH];
   logic [3:0]                    model_front = '0;
   logic [4:0]                    model_count = '0;
   bit                            model_flipped = 1'b0;

   bdqs_pkg::rsp_type             answers_due [$];
   logic [bdqs_pkg::KEY_IN_W-1:0] key_pool [8];
   stim_row_type                  plan [25];
   int                            error_count = 0;
   bit                            filling = 1'b1;

   bounded_deque_with_search #(.DEPTH(DEPTH), .KEY_WIDTH(bdqs_pkg::KEY_IN_W)) dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_word   (req_word),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   task automatic note_error(input string msg);
      $display("mismatch: %s", msg);
      error_count++;
   endtask

   function automatic bdqs_pkg::rsp_type answer(input bdqs_pkg::status_type s,
                                                input int p, input int n);
      bdqs_pkg::rsp_type r;
      r.status = s;
      r.found_position = p[bdqs_pkg::POS_W-1:0];
      r.entry_total = n[bdqs_pkg::TOTAL_W-1:0];
      return r;
   endfunction

   function automatic stim_row_type row(input logic [bdqs_pkg::KIND_W-1:0] k,
                                        input logic [bdqs_pkg::KEY_IN_W-1:0] v,
                                        input int n, input bit t,
                                        input bdqs_pkg::rsp_type e);
      stim_row_type s;
      s.kind = k;
      s.key = v;
      s.reps = n[4:0];
      s.typed = t;
      s.want = e;
      return s;
   endfunction

   // deque state update and the answer it gives for one word
   task automatic run_deque_op(input bdqs_pkg::req_type w, output bdqs_pkg::rsp_type r);
      int         i;
      logic [3:0] off;
      bit         hit;
      r = '0;
      r.status = bdqs_pkg::STATUS_OK;
      hit = 1'b0;
      unique case (w.kind)
         bdqs_pkg::KIND_PUSH_HEAD, bdqs_pkg::KIND_PUSH_TAIL: begin
            if (model_count == DEPTH) begin
               r.status = bdqs_pkg::STATUS_FULL;
            end else if ((w.kind == bdqs_pkg::KIND_PUSH_HEAD) != model_flipped) begin
               model_front = model_front - 1'b1;
               model_keys[model_front] = w.key_value;
               model_count++;
            end else begin
               model_keys[4'(model_front + model_count[3:0])] = w.key_value;
               model_count++;
            end
         end
         bdqs_pkg::KIND_POP_HEAD, bdqs_pkg::KIND_POP_TAIL: begin
            if (model_count == 0) begin
               r.status = bdqs_pkg::STATUS_EMPTY;
            end else if ((w.kind == bdqs_pkg::KIND_POP_HEAD) != model_flipped) begin
               model_front = model_front + 1'b1;
               model_count--;
            end else begin
               model_count--;
            end
         end
         bdqs_pkg::KIND_SEARCH: begin
            if (model_count == 0) begin
               r.status = bdqs_pkg::STATUS_EMPTY;
            end else begin
               r.status = bdqs_pkg::STATUS_NOTFOUND;
               for (i = 0; i < model_count && !hit; i++) begin
                  off = model_flipped ? 4'(model_count - 1 - i) : 4'(i);
                  if (model_keys[4'(model_front + off)] == w.key_value) begin
                     hit = 1'b1;
                     r.status = bdqs_pkg::STATUS_OK;
                     r.found_position = 4'(i);
                  end
               end
            end
         end
         bdqs_pkg::KIND_REVERSE: begin
            if (model_count == 0) r.status = bdqs_pkg::STATUS_EMPTY;
            else model_flipped = !model_flipped;
         end
         default: begin
         end
      endcase
      r.entry_total = model_count;
   endtask

   // offer one word, wait for it to be taken, then maybe hold off the next
   task automatic send_word(input bdqs_pkg::req_type w, input bit allow_gap, input bit typed,
                            input bdqs_pkg::rsp_type want);
      bdqs_pkg::rsp_type r;
      logic [63:0]       noise;
      start <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (busy);
      run_deque_op(w, r);
      answers_due.push_back(typed ? want : r);
      if (allow_gap && $urandom_range(99) < 30) begin
         noise = {$urandom, $urandom};
         start <= 1'b0;
         req_word <= noise[$bits(bdqs_pkg::req_type)-1:0];
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic pick_word(output bdqs_pkg::req_type w);
      int roll;
      roll = $urandom_range(99);
      w.key_value = $urandom;
      if (model_count == DEPTH) filling = 1'b0;
      else if (model_count == 0) filling = 1'b1;
      else if ($urandom_range(49) == 0) filling = !filling;
      if (roll < 3) begin
         w.kind = roll[0] ? KIND_SPARE_7 : KIND_SPARE_6;
      end else if (roll < 10) begin
         w.kind = bdqs_pkg::KIND_REVERSE;
      end else if (roll < 40) begin
         w.kind = bdqs_pkg::KIND_SEARCH;
         if (model_count != 0 && $urandom_range(99) < 60)
            w.key_value = model_keys[4'(model_front + 4'($urandom_range(model_count - 1)))];
         else if ($urandom_range(99) < 50)
            w.key_value = key_pool[$urandom_range(7)];
      end else if (roll < (filling ? 85 : 55)) begin
         w.kind = $urandom_range(1) ? bdqs_pkg::KIND_PUSH_HEAD : bdqs_pkg::KIND_PUSH_TAIL;
         if ($urandom_range(1)) w.key_value = key_pool[$urandom_range(7)];
      end else begin
         w.kind = $urandom_range(1) ? bdqs_pkg::KIND_POP_HEAD : bdqs_pkg::KIND_POP_TAIL;
      end
   endtask

   always @(posedge clock) begin : watch_results
      bdqs_pkg::rsp_type want;
      if (!reset && rsp_strobe !== 1'b0) begin
         if (answers_due.size() == 0) begin
            note_error("result word with none awaited");
         end else begin
            want = answers_due.pop_front();
            if (rsp_word.status !== want.status)
               note_error($sformatf("status expected %0d got %0d",
                                    want.status, rsp_word.status));
            if (rsp_word.found_position !== want.found_position)
               note_error($sformatf("found_position expected %0d got %0d",
                                    want.found_position, rsp_word.found_position));
            if (rsp_word.entry_total !== want.entry_total)
               note_error($sformatf("entry_total expected %0d got %0d",
                                    want.entry_total, rsp_word.entry_total));
         end
      end
   end

   initial begin : stimulus
      bdqs_pkg::req_type w;
      int                n;
      int                j;
      int                taken;
      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hffff_ffff;
      key_pool[2] = 32'h7fff_ffff;
      key_pool[3] = 32'h8000_0000;
      for (n = 4; n < 8; n++) key_pool[n] = $urandom;

      plan[0]  = row(bdqs_pkg::KIND_SEARCH,    32'h0,         1, 1,
                     answer(bdqs_pkg::STATUS_EMPTY, 0, 0));
      plan[1]  = row(bdqs_pkg::KIND_POP_HEAD,  32'h0,         1, 1,
                     answer(bdqs_pkg::STATUS_EMPTY, 0, 0));
      plan[2]  = row(bdqs_pkg::KIND_POP_TAIL,  32'h0,         1, 1,
                     answer(bdqs_pkg::STATUS_EMPTY, 0, 0));
      plan[3]  = row(bdqs_pkg::KIND_REVERSE,   32'h0,         1, 1,
                     answer(bdqs_pkg::STATUS_EMPTY, 0, 0));
      plan[4]  = row(KIND_SPARE_6,             32'hffff_ffff, 1, 1,
                     answer(bdqs_pkg::STATUS_OK, 0, 0));
      plan[5]  = row(KIND_SPARE_7,             32'h0,         1, 1,
                     answer(bdqs_pkg::STATUS_OK, 0, 0));
      plan[6]  = row(bdqs_pkg::KIND_PUSH_HEAD, 32'h7fff_ffff, 1, 1,
                     answer(bdqs_pkg::STATUS_OK, 0, 1));
      plan[7]  = row(bdqs_pkg::KIND_PUSH_TAIL, 32'h8000_0000, 1, 1,
                     answer(bdqs_pkg::STATUS_OK, 0, 2));
      plan[8]  = row(bdqs_pkg::KIND_PUSH_HEAD, 32'h0,         1, 1,
                     answer(bdqs_pkg::STATUS_OK, 0, 3));
      plan[9]  = row(bdqs_pkg::KIND_PUSH_TAIL, 32'hffff_ffff, 1, 1,
                     answer(bdqs_pkg::STATUS_OK, 0, 4));
      plan[10] = row(bdqs_pkg::KIND_SEARCH,    32'h8000_0000, 1, 0, '0);
      plan[11] = row(bdqs_pkg::KIND_SEARCH,    32'h0001_2345, 1, 0, '0);
      plan[12] = row(bdqs_pkg::KIND_REVERSE,   32'h0,         1, 0, '0);
      plan[13] = row(bdqs_pkg::KIND_SEARCH,    32'hffff_ffff, 1, 0, '0);
      plan[14] = row(bdqs_pkg::KIND_PUSH_HEAD, 32'h5555_5555, 1, 0, '0);
      plan[15] = row(bdqs_pkg::KIND_PUSH_TAIL, 32'haaaa_aaaa, 1, 0, '0);
      plan[16] = row(bdqs_pkg::KIND_POP_HEAD,  32'h0,         1, 0, '0);
      plan[17] = row(bdqs_pkg::KIND_POP_TAIL,  32'h0,         1, 0, '0);
      plan[18] = row(bdqs_pkg::KIND_PUSH_TAIL, 32'd100,      12, 0, '0);
      plan[19] = row(bdqs_pkg::KIND_PUSH_HEAD, 32'h1234_5678, 1, 1,
                     answer(bdqs_pkg::STATUS_FULL, 0, 16));
      plan[20] = row(bdqs_pkg::KIND_PUSH_TAIL, 32'h8765_4321, 1, 1,
                     answer(bdqs_pkg::STATUS_FULL, 0, 16));
      plan[21] = row(bdqs_pkg::KIND_SEARCH,    32'd111,       1, 0, '0);
      plan[22] = row(KIND_SPARE_6,             32'h0,         1, 0, '0);
      plan[23] = row(bdqs_pkg::KIND_POP_HEAD,  32'h0,        16, 0, '0);
      plan[24] = row(bdqs_pkg::KIND_REVERSE,   32'h0,         1, 1,
                     answer(bdqs_pkg::STATUS_EMPTY, 0, 0));

      reset <= 1'b1;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < 25; n++) begin
         for (j = 0; j < plan[n].reps; j++) begin
            w.kind = plan[n].kind;
            w.key_value = plan[n].key + j;
            send_word(w, 1'b1, plan[n].typed, plan[n].want);
         end
      end

      taken = 0;
      while (taken < RANDOM_WORDS) begin
         pick_word(w);
         send_word(w, taken < RANDOM_WORDS - CALM_WORDS, 1'b0, '0);
         if (w.kind <= bdqs_pkg::KIND_REVERSE) taken++;
      end
      start <= 1'b0;

      while (answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
